// ===== rtl/core/cau_pkg.sv =====
package cau_pkg;

  localparam int unsigned FRAC_BITS = 16;
  // quotient bits kept by the divider; anything at or above 2^QB is flagged as overflow
  localparam int unsigned QB = 33;
  // partial remainder width: holds den << QB and the shifted dividend magnitude
  localparam int unsigned DIV_W = 64 + QB + 1;
  // input reg, product, sum, prep, QB+1 divider ranks, output reg
  localparam int unsigned LATENCY = QB + 6;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_SMUL = 3'd4,
    OP_SDIV = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QB-1:0]    quo;
    logic             ovf;
    logic             neg;
  } dlane_t;

  typedef struct packed {
    logic        is_div;
    logic        dz;
    logic [63:0] den;
    logic [31:0] d_re;
    logic [31:0] d_im;
    status_e     d_st;
    dlane_t      re;
    dlane_t      im;
  } dstage_t;

  function automatic sat_t sat32(input logic signed [64:0] v);
    sat_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > 65'sd2147483647) begin
      r.val = 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end else if (v < -65'sd2147483648) begin
      r.val = 32'h8000_0000;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  // one restoring step against den << sh
  function automatic dlane_t div_step(input dlane_t x, input logic [63:0] den,
                                      input int unsigned sh);
    dlane_t           r;
    logic [DIV_W-1:0] dsh;
    r   = x;
    dsh = DIV_W'(den) << sh;
    if (x.rem >= dsh) begin
      r.rem = x.rem - dsh;
      r.quo = {x.quo[QB-2:0], 1'b1};
    end else begin
      r.quo = {x.quo[QB-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic sat_t div_fin(input dlane_t x);
    sat_t          r;
    logic [QB-1:0] nq;
    nq    = ~x.quo + 1'b1;
    r.sat = 1'b0;
    if (x.neg) begin
      if (x.ovf || x.quo > QB'(32'h8000_0000)) begin
        r.val = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.val = nq[31:0];
      end
    end else begin
      if (x.ovf || x.quo > QB'(32'h7FFF_FFFF)) begin
        r.val = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else begin
        r.val = x.quo[31:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/complex_arith_unit.sv =====
// Every op passes input reg, product, sum, prep, divider ranks and output reg to valid_o.
// Throughput: one item per cycle; busy_o stays low, a new item may start in every cycle.
// The depth is set by the divider: an entry rank for the overflow check, then one
// quotient bit per rank over 33 ranks, shared by complex divide and scale divide.
// Reset clears the valid bits only; payload registers are not reset.
// valid_o is a one-cycle strobe; the receiver cannot stall.
module complex_arith_unit
  import cau_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] a_re_i,
  input  logic [31:0] a_im_i,
  input  logic [31:0] b_re_i,
  input  logic [31:0] b_im_i,
  input  logic [15:0] scale_i,
  output logic        valid_o,
  output logic [31:0] res_re_o,
  output logic [31:0] res_im_o,
  output logic [1:0]  status_o
);

  logic in_xfer;
  assign busy_o  = 1'b0;
  assign in_xfer = start_i & ~busy_o;

  // stage 1: operand register
  logic        v1_q;
  op_e         op1_q;
  logic [31:0] ar1_q, ai1_q, br1_q, bi1_q;
  logic [15:0] sc1_q;

  // stage 2: products
  logic               v2_q;
  op_e                op2_q;
  logic signed [63:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_b0_q, p_b1_q;
  logic signed [63:0] p_rr_d, p_ii_d, p_ri_d, p_ir_d, p_b0_d, p_b1_d;
  logic [32:0]        as_re_q, as_im_q, as_re_d, as_im_d;
  logic [31:0]        ar2_q, ai2_q;
  logic [15:0]        sc2_q;
  logic signed [31:0] x0;

  // stage 3: sums
  logic               v3_q;
  op_e                op3_q;
  logic signed [64:0] acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic [63:0]        den3_q, den3_d;

  // stage 4: saturation of direct results, divider operands
  logic        v4_q;
  logic        isdiv4_q, isdiv4_d;
  logic [63:0] den4_q;
  logic [31:0] dre4_q, dim4_q;
  status_e     dst4_q, dst4_d;
  sat_t        s_re, s_im;
  logic [63:0] mag_re, mag_im;
  logic [DIV_W-1:0] n_re4_q, n_im4_q, n_re4_d, n_im4_d;
  logic        neg_re4_q, neg_im4_q;

  // divider ranks
  logic    dv_q [QB+1];
  dstage_t ds_q [QB+1];
  dstage_t ds0_d;
  dstage_t ds_n [QB];

  // output
  logic        vo_q;
  logic [31:0] ore_q, oim_q;
  status_e     ost_q;
  sat_t        f_re, f_im;
  logic [31:0] ore_d, oim_d;
  status_e     ost_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      for (int k = 0; k <= QB; k++) dv_q[k] <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q    <= in_xfer;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      dv_q[0] <= v4_q;
      for (int k = 0; k < QB; k++) dv_q[k+1] <= dv_q[k];
      vo_q <= dv_q[QB];
    end
  end

  // stage 2 logic
  always_comb begin
    x0 = (op1_q == OP_SMUL) ? $signed({{16{sc1_q[15]}}, sc1_q}) : $signed(br1_q);
    p_rr_d = $signed(ar1_q) * x0;
    p_ir_d = $signed(ai1_q) * x0;
    p_ii_d = $signed(ai1_q) * $signed(bi1_q);
    p_ri_d = $signed(ar1_q) * $signed(bi1_q);
    p_b0_d = $signed(br1_q) * $signed(br1_q);
    p_b1_d = $signed(bi1_q) * $signed(bi1_q);
    if (op1_q == OP_SUB) begin
      as_re_d = {ar1_q[31], ar1_q} - {br1_q[31], br1_q};
      as_im_d = {ai1_q[31], ai1_q} - {bi1_q[31], bi1_q};
    end else begin
      as_re_d = {ar1_q[31], ar1_q} + {br1_q[31], br1_q};
      as_im_d = {ai1_q[31], ai1_q} + {bi1_q[31], bi1_q};
    end
  end

  // stage 3 logic: one signed 65-bit value per part
  always_comb begin
    acc_re_d = '0;
    acc_im_d = '0;
    den3_d   = '0;
    case (op2_q)
      OP_ADD, OP_SUB: begin
        acc_re_d = {{32{as_re_q[32]}}, as_re_q};
        acc_im_d = {{32{as_im_q[32]}}, as_im_q};
      end
      OP_MUL: begin
        acc_re_d = {p_rr_q[63], p_rr_q} - {p_ii_q[63], p_ii_q};
        acc_im_d = {p_ri_q[63], p_ri_q} + {p_ir_q[63], p_ir_q};
      end
      OP_DIV: begin
        acc_re_d = {p_rr_q[63], p_rr_q} + {p_ii_q[63], p_ii_q};
        acc_im_d = {p_ir_q[63], p_ir_q} - {p_ri_q[63], p_ri_q};
        den3_d   = $unsigned(p_b0_q) + $unsigned(p_b1_q);
      end
      OP_SMUL: begin
        acc_re_d = {p_rr_q[63], p_rr_q};
        acc_im_d = {p_ir_q[63], p_ir_q};
      end
      OP_SDIV: begin
        // divisor magnitude goes to the divider, its sign folds into the dividend
        acc_re_d = {{33{ar2_q[31]}}, ar2_q};
        acc_im_d = {{33{ai2_q[31]}}, ai2_q};
        if (sc2_q[15]) begin
          acc_re_d = -$signed({{33{ar2_q[31]}}, ar2_q});
          acc_im_d = -$signed({{33{ai2_q[31]}}, ai2_q});
        end
        den3_d   = {48'd0, sc2_q[15] ? (~sc2_q + 16'd1) : sc2_q};
      end
      default: ;
    endcase
  end

  // stage 4 logic
  always_comb begin
    mag_re = acc_re_q[64] ? 64'(-acc_re_q) : acc_re_q[63:0];
    mag_im = acc_im_q[64] ? 64'(-acc_im_q) : acc_im_q[63:0];
    n_re4_d = DIV_W'(mag_re);
    n_im4_d = DIV_W'(mag_im);
    if (op3_q == OP_DIV) begin
      n_re4_d = DIV_W'(mag_re) << FRAC_BITS;
      n_im4_d = DIV_W'(mag_im) << FRAC_BITS;
    end
    isdiv4_d = (op3_q == OP_DIV) || (op3_q == OP_SDIV);
    if (op3_q == OP_MUL) begin
      s_re = sat32(acc_re_q >>> FRAC_BITS);
      s_im = sat32(acc_im_q >>> FRAC_BITS);
    end else begin
      s_re = sat32(acc_re_q);
      s_im = sat32(acc_im_q);
    end
    dst4_d = (s_re.sat || s_im.sat) ? ST_SAT : ST_OK;
  end

  // divider entry: overflow check against den << QB
  always_comb begin
    ds0_d.is_div = isdiv4_q;
    ds0_d.dz     = (den4_q == '0);
    ds0_d.den    = den4_q;
    ds0_d.d_re   = dre4_q;
    ds0_d.d_im   = dim4_q;
    ds0_d.d_st   = dst4_q;
    ds0_d.re.rem = n_re4_q;
    ds0_d.re.quo = '0;
    ds0_d.re.ovf = n_re4_q >= (DIV_W'(den4_q) << QB);
    ds0_d.re.neg = neg_re4_q;
    ds0_d.im.rem = n_im4_q;
    ds0_d.im.quo = '0;
    ds0_d.im.ovf = n_im4_q >= (DIV_W'(den4_q) << QB);
    ds0_d.im.neg = neg_im4_q;
  end

  // one restoring step per rank
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      ds_n[k]    = ds_q[k];
      ds_n[k].re = div_step(ds_q[k].re, ds_q[k].den, QB - 1 - k);
      ds_n[k].im = div_step(ds_q[k].im, ds_q[k].den, QB - 1 - k);
    end
  end

  // output selection
  always_comb begin
    f_re  = div_fin(ds_q[QB].re);
    f_im  = div_fin(ds_q[QB].im);
    ore_d = ds_q[QB].d_re;
    oim_d = ds_q[QB].d_im;
    ost_d = ds_q[QB].d_st;
    if (ds_q[QB].is_div) begin
      if (ds_q[QB].dz) begin
        ore_d = '0;
        oim_d = '0;
        ost_d = ST_DZ;
      end else begin
        ore_d = f_re.val;
        oim_d = f_im.val;
        ost_d = (f_re.sat || f_im.sat) ? ST_SAT : ST_OK;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op1_q <= op_e'(op_i);
    ar1_q <= a_re_i;
    ai1_q <= a_im_i;
    br1_q <= b_re_i;
    bi1_q <= b_im_i;
    sc1_q <= scale_i;

    op2_q   <= op1_q;
    p_rr_q  <= p_rr_d;
    p_ii_q  <= p_ii_d;
    p_ri_q  <= p_ri_d;
    p_ir_q  <= p_ir_d;
    p_b0_q  <= p_b0_d;
    p_b1_q  <= p_b1_d;
    as_re_q <= as_re_d;
    as_im_q <= as_im_d;
    ar2_q   <= ar1_q;
    ai2_q   <= ai1_q;
    sc2_q   <= sc1_q;

    op3_q    <= op2_q;
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    den3_q   <= den3_d;

    isdiv4_q  <= isdiv4_d;
    den4_q    <= den3_q;
    dre4_q    <= s_re.val;
    dim4_q    <= s_im.val;
    dst4_q    <= dst4_d;
    n_re4_q   <= n_re4_d;
    n_im4_q   <= n_im4_d;
    neg_re4_q <= acc_re_q[64];
    neg_im4_q <= acc_im_q[64];

    ds_q[0] <= ds0_d;
    for (int k = 0; k < QB; k++) ds_q[k+1] <= ds_n[k];

    ore_q <= ore_d;
    oim_q <= oim_d;
    ost_q <= ost_d;
  end

  assign valid_o  = vo_q;
  assign res_re_o = ore_q;
  assign res_im_o = oim_q;
  assign status_o = ost_q;

`ifndef ASSERT_OFF
  a_start_to_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##LATENCY valid_o)
    else $error("accepted item produced no result strobe");

  a_strobe_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(in_xfer, LATENCY))
    else $error("result strobe without an accepted item");

  a_dz_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == ST_DZ |-> res_re_o == '0 && res_im_o == '0)
    else $error("divide by zero with nonzero result");
`endif

endmodule
